// ===== rtl/core/voxel_face_culling_macros.svh =====
// assertion macros for the voxel face culling block
// no dependencies; taken in by include in the files that assert
`ifndef VOXEL_FACE_CULLING_MACROS_SVH
`define VOXEL_FACE_CULLING_MACROS_SVH

// same-cycle implication
`define VFC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vfc assertion failed");

// next-cycle implication
`define VFC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vfc assertion failed");

`endif

// ===== rtl/core/vfc_pkg.sv =====
// item types, opcodes, face codes and sequencer states for voxel face culling
// no dependencies
`default_nettype none

package vfc_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MESH  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    FACE_RIGHT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_BACK   = 3'd4,
    FACE_FRONT  = 3'd5
  } face_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_HAND = 3'b100
  } state_e;

  localparam int unsigned NumFaces = 6;

  typedef struct packed {
    op_e         opcode;
    logic [3:0]  pos_x;
    logic [3:0]  pos_z;
    logic [7:0]  pos_y;
    logic [15:0] block_id;
    logic [5:0]  border_open;
  } in_item_t;

  typedef struct packed {
    face_e       face;
    logic [3:0]  out_x;
    logic [3:0]  out_z;
    logic [7:0]  out_y;
    logic [15:0] face_block;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/voxel_face_culling.sv =====
// voxel face culling top level: voxel id memory, read sequencer and face output stage
// depends on vfc_pkg and voxel_face_culling_macros.svh
//
// A write item stores its id in the voxel memory in the cycle it is accepted, so
// writes go at one per cycle while no mesh item is being read. A mesh item reads the
// centre voxel and then its six neighbours through the single port of the voxel
// memory, one read a cycle into the rdata_q register; the next item can be taken from
// the last read step on, once the face output stage holds no pending faces of the
// previous voxel. Visible faces then leave one per cycle, while out_ready_i is high,
// from an output register, right, left, top, bottom, back, front, with last set on
// the final one, while the next item is read.
// The memory holds WIDTH*DEPTH*HEIGHT 16-bit ids, is not cleared at reset, and a
// cell must be written before any mesh item touches it.
`default_nettype none
`include "voxel_face_culling_macros.svh"

module voxel_face_culling
  import vfc_pkg::*;
#(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned HEIGHT = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned Cells = WIDTH * DEPTH * HEIGHT;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned LastStep = NumFaces + 1;

  function automatic logic [AddrW-1:0] cell_addr(logic [3:0] x, logic [3:0] z,
                                                 logic [7:0] y);
    logic [31:0] s;
    s = (32'(x) * DEPTH + 32'(z)) * HEIGHT + 32'(y);
    return s[AddrW-1:0];
  endfunction

  // voxel memory
  logic [15:0]      mem [Cells];
  logic [AddrW-1:0] mem_addr;
  logic             mem_we;
  logic [15:0]      rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= in_item_i.block_id;
    end else begin
      rdata_q <= mem[mem_addr];
    end
  end

  // sequencer
  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  in_item_t   req_q;
  logic [15:0] self_q, self_d;
  logic [5:0] vis_q, vis_d;
  logic [5:0] emit_mask_q, emit_mask_d;
  logic       in_acc, in_range, handoff, hand_ready, vis_bit;
  logic [5:0] edge_hit;
  logic [2:0] fi, fr;
  logic [3:0] nx, nz;
  logic [7:0] ny;

  assign in_range = (32'(in_item_i.pos_x) < WIDTH) && (32'(in_item_i.pos_z) < DEPTH) &&
                    (32'(in_item_i.pos_y) < HEIGHT);
  assign hand_ready = (emit_mask_q == '0) &&
                      (((state_q == ST_READ) && (cnt_q == 3'(LastStep))) ||
                       (state_q == ST_HAND));
  assign in_ready_o = (state_q == ST_IDLE) || hand_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign mem_we     = in_acc && in_range && (in_item_i.opcode == OP_WRITE);

  assign edge_hit[0] = 32'(req_q.pos_x) == WIDTH - 1;
  assign edge_hit[1] = req_q.pos_x == '0;
  assign edge_hit[2] = 32'(req_q.pos_y) == HEIGHT - 1;
  assign edge_hit[3] = req_q.pos_y == '0;
  assign edge_hit[4] = 32'(req_q.pos_z) == DEPTH - 1;
  assign edge_hit[5] = req_q.pos_z == '0;

  // neighbour for the read issued this cycle
  assign fr = cnt_q - 3'd1;
  always_comb begin
    nx = req_q.pos_x;
    nz = req_q.pos_z;
    ny = req_q.pos_y;
    case (face_e'(fr))
      FACE_RIGHT:  nx = req_q.pos_x + 4'd1;
      FACE_LEFT:   nx = req_q.pos_x - 4'd1;
      FACE_TOP:    ny = req_q.pos_y + 8'd1;
      FACE_BOTTOM: ny = req_q.pos_y - 8'd1;
      FACE_BACK:   nz = req_q.pos_z + 4'd1;
      FACE_FRONT:  nz = req_q.pos_z - 4'd1;
      default: ;
    endcase
  end

  always_comb begin
    if (in_acc) begin
      mem_addr = cell_addr(in_item_i.pos_x, in_item_i.pos_z, in_item_i.pos_y);
    end else begin
      mem_addr = cell_addr(nx, nz, ny);
    end
  end

  // face for the read data arriving this cycle
  assign fi      = cnt_q - 3'd2;
  assign vis_bit = edge_hit[fi] ? req_q.border_open[fi] : (rdata_q == '0);

  always_comb begin
    vis_d  = vis_q;
    self_d = self_q;
    if (state_q == ST_READ) begin
      if (cnt_q == 3'd1) begin
        self_d = rdata_q;
      end else if (cnt_q >= 3'd2) begin
        vis_d[fi] = vis_bit;
      end
    end
  end

  assign handoff = ((state_q == ST_READ) && (cnt_q == 3'(LastStep))) || (state_q == ST_HAND);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (state_q == ST_READ) begin
      if (cnt_q == 3'(LastStep)) begin
        state_d = (emit_mask_q == '0) ? ST_IDLE : ST_HAND;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end else if (state_q == ST_HAND && emit_mask_q == '0) begin
      state_d = ST_IDLE;
    end
    if (in_acc) begin
      state_d = ST_IDLE;
      if (in_range && in_item_i.opcode == OP_MESH) begin
        state_d = ST_READ;
        cnt_d   = 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // face output stage
  in_item_t   emit_req_q;
  logic [15:0] emit_id_q;
  logic [5:0] sel;
  logic [2:0] sel_idx;
  logic       out_free, emit_fire, emit_load;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  assign emit_load = handoff && (emit_mask_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_fire = out_free && (emit_mask_q != '0);

  always_comb begin
    sel     = '0;
    sel_idx = '0;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (emit_mask_q[i]) begin
        sel     = 6'(1) << i;
        sel_idx = 3'(i);
      end
    end
  end

  always_comb begin
    emit_mask_d = emit_mask_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_fire) begin
      emit_mask_d      = emit_mask_q & ~sel;
      out_valid_d      = 1'b1;
      out_d.face       = face_e'(sel_idx);
      out_d.out_x      = emit_req_q.pos_x;
      out_d.out_z      = emit_req_q.pos_z;
      out_d.out_y      = emit_req_q.pos_y;
      out_d.face_block = emit_id_q;
      out_d.last       = (emit_mask_q & ~sel) == '0;
    end
    if (emit_load) begin
      emit_mask_d = (self_d != '0) ? vis_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      emit_mask_q <= emit_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q  <= vis_d;
    self_q <= self_d;
    out_q  <= out_d;
    if (in_acc) begin
      req_q <= in_item_i;
    end
    if (emit_load) begin
      emit_req_q <= req_q;
      emit_id_q  <= self_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `VFC_ASSERT_IMP(a_write_port_free, clk_i, rst_ni, mem_we,
                  state_q == ST_IDLE || hand_ready)
  `VFC_ASSERT_IMP(a_more_faces_pending, clk_i, rst_ni, out_valid_o && !out_item_o.last,
                  emit_mask_q != '0)
  `VFC_ASSERT_NXT(a_mesh_starts_reads, clk_i, rst_ni,
                  in_acc && in_range && in_item_i.opcode == OP_MESH,
                  state_q == ST_READ && cnt_q == 3'd1)

endmodule

`default_nettype wire

// ===== bench/tb_voxel_face_culling.sv =====
// testbench for voxel_face_culling: a scoreboard class keeps its own copy of the voxel ids
// and predicts the visible faces of every mesh item; depends on vfc_pkg and the rtl top level
module tb_voxel_face_culling;
  import vfc_pkg::*;

  localparam int unsigned Width  = 16;
  localparam int unsigned Depth  = 16;
  localparam int unsigned Height = 256;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 235;
  localparam int DrainLimit  = 50000;

  class face_scoreboard;
    logic [15:0] voxel_ids [int];
    out_item_t   face_q [$];
    int          errors = 0;

    function int cell_of(int x, int z, int y);
      return (x * Depth + z) * Height + y;
    endfunction

    function bit air_at(int x, int z, int y);
      int idx;
      idx = cell_of(x, z, y);
      if (!voxel_ids.exists(idx)) return 1'b1;
      return voxel_ids[idx] == 16'd0;
    endfunction

    function int pending();
      return face_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task note_input(in_item_t it);
      int x, z, y, total, n;
      logic [15:0] self_id;
      bit vis [NumFaces];
      out_item_t e;
      x = it.pos_x;
      z = it.pos_z;
      y = it.pos_y;
      if (x >= Width || z >= Depth || y >= Height) return;
      if (it.opcode == OP_WRITE) begin
        voxel_ids[cell_of(x, z, y)] = it.block_id;
        return;
      end
      if (air_at(x, z, y)) return;
      self_id = voxel_ids[cell_of(x, z, y)];
      // chunk edges take the border bit, inside faces look at the neighbour
      vis[FACE_RIGHT]  = (x == Width - 1)  ? it.border_open[FACE_RIGHT]  : air_at(x + 1, z, y);
      vis[FACE_LEFT]   = (x == 0)          ? it.border_open[FACE_LEFT]   : air_at(x - 1, z, y);
      vis[FACE_TOP]    = (y == Height - 1) ? it.border_open[FACE_TOP]    : air_at(x, z, y + 1);
      vis[FACE_BOTTOM] = (y == 0)          ? it.border_open[FACE_BOTTOM] : air_at(x, z, y - 1);
      vis[FACE_BACK]   = (z == Depth - 1)  ? it.border_open[FACE_BACK]   : air_at(x, z + 1, y);
      vis[FACE_FRONT]  = (z == 0)          ? it.border_open[FACE_FRONT]  : air_at(x, z - 1, y);
      total = 0;
      for (int f = 0; f < NumFaces; f++) total += vis[f];
      n = 0;
      for (int f = 0; f < NumFaces; f++) begin
        if (vis[f]) begin
          e.face       = face_e'(f);
          e.out_x      = it.pos_x;
          e.out_z      = it.pos_z;
          e.out_y      = it.pos_y;
          e.face_block = self_id;
          e.last       = (n == total - 1);
          face_q = {face_q, e};
          n++;
        end
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (face_q.size() == 0) begin
        report($sformatf("unexpected face %0d at (%0d,%0d,%0d)",
                         got.face, got.out_x, got.out_z, got.out_y));
        return;
      end
      want = face_q.pop_front();
      if (got.face !== want.face)
        report($sformatf("face got %0d want %0d", got.face, want.face));
      if (got.out_x !== want.out_x)
        report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
      if (got.out_z !== want.out_z)
        report($sformatf("out_z got %0d want %0d", got.out_z, want.out_z));
      if (got.out_y !== want.out_y)
        report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
      if (got.face_block !== want.face_block)
        report($sformatf("face_block got %h want %h", got.face_block, want.face_block));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic      clk;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  face_scoreboard sb;
  bit  calm;
  int  hold_asks;
  int  sent;
  bit  seen [int];
  int  centres [$];
  int  dx [NumFaces] = '{1, -1, 0, 0, 0, 0};
  int  dy [NumFaces] = '{0, 0, 1, -1, 0, 0};
  int  dz [NumFaces] = '{0, 0, 0, 0, 1, -1};

  voxel_face_culling #(
    .WIDTH (Width),
    .DEPTH (Depth),
    .HEIGHT(Height)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_ni && in_valid && in_ready) sb.note_input(in_item);
    if (rst_ni && out_valid && out_ready) sb.check_result(out_item);
  end

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function bit in_chunk(int x, int z, int y);
    return x >= 0 && x < Width && z >= 0 && z < Depth && y >= 0 && y < Height;
  endfunction

  // a mesh item may only touch cells that have been written
  function bit meshable(int x, int z, int y);
    if (!seen.exists(sb.cell_of(x, z, y))) return 1'b0;
    for (int i = 0; i < NumFaces; i++) begin
      if (in_chunk(x + dx[i], z + dz[i], y + dy[i]) &&
          !seen.exists(sb.cell_of(x + dx[i], z + dz[i], y + dy[i]))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function int gap_len();
    int n;
    n = 0;
    if (calm) return 0;
    while ($urandom_range(99) < 35 && n < 15) n++;
    return n;
  endfunction

  function logic [15:0] rand_id(int air_pct);
    logic [15:0] r;
    if ($urandom_range(99) < air_pct) return 16'd0;
    if ($urandom_range(9) == 0) return 16'hFFFF;
    r = 16'($urandom_range(65535));
    return (r == 16'd0) ? 16'd1 : r;
  endfunction

  function int pick_coord(int hi);
    case ($urandom_range(5))
      0:       return 0;
      1:       return hi - 1;
      default: return $urandom_range(hi - 1);
    endcase
  endfunction

  task send_item(in_item_t it);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task put(op_e op, int x, int z, int y, logic [15:0] id, logic [5:0] border);
    in_item_t it;
    it.opcode      = op;
    it.pos_x       = 4'(x);
    it.pos_z       = 4'(z);
    it.pos_y       = 8'(y);
    it.block_id    = id;
    it.border_open = border;
    if (op == OP_WRITE) seen[sb.cell_of(x, z, y)] = 1'b1;
    send_item(it);
  endtask

  task mesh(int x, int z, int y, logic [5:0] border);
    if (meshable(x, z, y)) put(OP_MESH, x, z, y, 16'($urandom), border);
  endtask

  task write_around(int x, int z, int y);
    for (int i = 0; i < NumFaces; i++) begin
      if (in_chunk(x + dx[i], z + dz[i], y + dy[i]))
        put(OP_WRITE, x + dx[i], z + dz[i], y + dy[i], rand_id(50), 6'($urandom));
    end
  endtask

  initial begin
    int cx, cz, cy, nx, nz, ny, i, code, base, k, waited;
    sb        = new;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    calm      = 1'b0;
    hold_asks = 0;
    sent      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // low corner with air inside neighbours: all six faces, then only the inside ones
    put(OP_WRITE, 0, 0, 0, 16'hFFFF, 6'h3F);
    put(OP_WRITE, 1, 0, 0, 16'h0000, 6'h00);
    put(OP_WRITE, 0, 1, 0, 16'h0000, 6'h00);
    put(OP_WRITE, 0, 0, 1, 16'h0000, 6'h00);
    mesh(0, 0, 0, 6'h3F);
    mesh(0, 0, 0, 6'h00);
    // high corner buried in solid cells: hidden, then edge faces only
    put(OP_WRITE, 15, 15, 255, 16'h0001, 6'h00);
    put(OP_WRITE, 14, 15, 255, 16'h8000, 6'h3F);
    put(OP_WRITE, 15, 14, 255, 16'h7FFF, 6'h15);
    put(OP_WRITE, 15, 15, 254, 16'hFFFF, 6'h2A);
    mesh(15, 15, 255, 6'h00);
    mesh(15, 15, 255, 6'h3F);
    // air voxel gives nothing
    put(OP_WRITE, 2, 0, 0, 16'h0000, 6'h3F);
    put(OP_WRITE, 1, 1, 0, 16'h0000, 6'h00);
    put(OP_WRITE, 1, 0, 1, 16'h0000, 6'h00);
    mesh(1, 0, 0, 6'h3F);
    // inside voxel with all border bits set: they are ignored
    cx = 8;
    cz = 8;
    cy = 128;
    write_around(cx, cz, cy);
    put(OP_WRITE, cx, cz, cy, 16'h5A5A, 6'h00);
    mesh(cx, cz, cy, 6'h3F);

    base = sent;
    k    = 0;
    while (sent - base < RandomItems) begin
      calm = (k >= 10 && k < 14);
      if (k == 6) hold_asks++;
      if (k == 18) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      cx = pick_coord(Width);
      cz = pick_coord(Depth);
      cy = pick_coord(Height);
      write_around(cx, cz, cy);
      put(OP_WRITE, cx, cz, cy, rand_id(10), 6'($urandom));
      centres = {centres, (cx << 16) | (cz << 8) | cy};
      repeat ($urandom_range(1, 2)) mesh(cx, cz, cy, 6'($urandom));
      if ($urandom_range(99) < 40) begin
        i  = $urandom_range(NumFaces - 1);
        nx = cx + dx[i];
        nz = cz + dz[i];
        ny = cy + dy[i];
        if (in_chunk(nx, nz, ny)) put(OP_WRITE, nx, nz, ny, rand_id(50), 6'($urandom));
        mesh(cx, cz, cy, 6'($urandom));
      end
      if ($urandom_range(99) < 30) begin
        i = $urandom_range(NumFaces - 1);
        nx = cx + dx[i];
        nz = cz + dz[i];
        ny = cy + dy[i];
        if (in_chunk(nx, nz, ny)) mesh(nx, nz, ny, 6'($urandom));
      end
      if ($urandom_range(99) < 25)
        put(OP_WRITE, $urandom_range(Width - 1), $urandom_range(Depth - 1),
            $urandom_range(Height - 1), rand_id(30), 6'($urandom));
      if ($urandom_range(99) < 30) begin
        code = centres[$urandom_range(centres.size() - 1)];
        mesh((code >> 16) & 8'hFF, (code >> 8) & 8'hFF, code & 8'hFF, 6'($urandom));
      end
      k++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected faces never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
